// ----- hw/rtl/crst_pkg.sv -----
// types and constants shared by the crypto stream reassembly tracker
// no dependencies
`timescale 1ns / 1ps

package crst_pkg;

  localparam int LevelW = 2;
  localparam int OffW   = 62;
  localparam int LenW   = 16;
  localparam int SlotW  = 4;
  localparam int HeldW  = 5;

  localparam logic [1:0] KIND_COPY  = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;
  localparam logic [1:0] KIND_FINAL = 2'd3;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [OffW-1:0]   frame_offset;
    logic [LenW-1:0]   frame_length;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SlotW-1:0] slot;
    logic [LenW-1:0]  skip_bytes;
    logic [OffW-1:0]  dest_offset;
    logic [LenW-1:0]  copy_length;
    logic             status;
    logic [OffW-1:0]  delivered_upto;
    logic [HeldW-1:0] held_segments;
    logic             last;
  } out_t;

endpackage

// ----- hw/rtl/crst_ram.sv -----
// single write port, single read port synchronous memory, registered read data
// no dependencies
`timescale 1ns / 1ps

module crst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/crypto_stream_reassembly_tracker.sv -----
// top level of the crypto stream reassembly tracker: control sequencer and state
// depends on crst_pkg and crst_ram
`timescale 1ns / 1ps

// Takes one frame descriptor at a time and returns its copy, store and move
// commands followed by a final status beat (last set). Segment offsets and lengths
// live in one memory and each level's newest-first segment order lives in a second
// memory used as a ring; delivery points, ring heads, counts and slot valid bits
// are in flops. Outside draining, a frame goes through evaluate, the final beat and
// back to idle. Each drain pass adds a start step plus, per held segment, a ring
// read, a segment read and a compare with write back, and passes repeat until one
// moves nothing or a held segment overruns the buffer. A rejected frame goes from
// evaluate straight to the final beat; output stalls can lengthen any frame.
module crypto_stream_reassembly_tracker #(
  parameter int LEVELS       = 4,
  parameter int MAX_SEGMENTS = 16,
  parameter int BUFFER_BYTES = 16384
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crst_pkg::in_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output crst_pkg::out_t out_o
);
  import crst_pkg::*;

  localparam int LvW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PosW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CntW   = $clog2(MAX_SEGMENTS + 1);
  localparam int TailW  = CntW + 1;
  localparam int NSlots = LEVELS * MAX_SEGMENTS;
  localparam int AddrW  = (NSlots > 1) ? $clog2(NSlots) : 1;
  localparam int SegW   = OffW + LenW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DRD    = 3'd3;
  localparam logic [2:0] ST_DSLOT  = 3'd4;
  localparam logic [2:0] ST_DCHK   = 3'd5;
  localparam logic [2:0] ST_FINAL  = 3'd6;

  function automatic logic [AddrW-1:0] taddr(logic [LvW-1:0] l, logic [PosW-1:0] p);
    return AddrW'(l) * AddrW'(MAX_SEGMENTS) + AddrW'(p);
  endfunction

  function automatic logic [PosW-1:0] pos_dec(logic [PosW-1:0] p);
    return (p == '0) ? PosW'(MAX_SEGMENTS - 1) : p - PosW'(1);
  endfunction

  function automatic logic [PosW-1:0] pos_inc(logic [PosW-1:0] p);
    return (p == PosW'(MAX_SEGMENTS - 1)) ? '0 : p + PosW'(1);
  endfunction

  logic [2:0]      st_q, st_d;
  in_t             in_q, in_d;
  logic [OffW-1:0] dp_q [LEVELS];
  logic [OffW-1:0] dp_d [LEVELS];
  logic [PosW-1:0] head_q [LEVELS];
  logic [PosW-1:0] head_d [LEVELS];
  logic [CntW-1:0] cnt_q [LEVELS];
  logic [CntW-1:0] cnt_d [LEVELS];
  logic [NSlots-1:0] valid_q, valid_d;
  logic [PosW-1:0] p_q, p_d, w_q, w_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            prog_q, prog_d, err_q, err_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic             seg_we, seg_re, ring_we, ring_re;
  logic [AddrW-1:0] seg_waddr, seg_raddr, ring_waddr, ring_raddr;
  logic [SegW-1:0]  seg_wdata, seg_rdata;
  logic [PosW-1:0]  ring_wdata, ring_rdata;

  crst_ram #(.Width(SegW), .Depth(NSlots)) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (seg_we),
    .waddr_i(seg_waddr),
    .wdata_i(seg_wdata),
    .re_i   (seg_re),
    .raddr_i(seg_raddr),
    .rdata_o(seg_rdata)
  );

  crst_ram #(.Width(PosW), .Depth(NSlots)) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .re_i   (ring_re),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  logic [LvW-1:0]  lv_idx;
  logic            bad_lv;
  logic [OffW-1:0] dp_cur;
  logic [CntW-1:0] cnt_cur;
  logic [PosW-1:0] head_cur, tail_cur, free_slot;
  logic [TailW-1:0] tail_sum;
  logic            out_free;
  logic            below, dup, at_dp, over;
  logic [OffW-1:0] diff;
  logic [LenW-1:0] skip, elen;
  logic [OffW:0]   sum;
  logic [OffW-1:0] s_off;
  logic [LenW-1:0] s_len;
  logic [OffW:0]   s_sum;
  logic            s_over, s_match, keep;
  logic [PosW-1:0] w_next;

  always_comb begin
    lv_idx   = LvW'(in_q.level);
    bad_lv   = 32'(in_q.level) >= LEVELS;
    dp_cur   = dp_q[lv_idx];
    cnt_cur  = cnt_q[lv_idx];
    head_cur = head_q[lv_idx];
    tail_sum = TailW'(head_cur) + TailW'(cnt_cur);
    if (tail_sum >= TailW'(MAX_SEGMENTS)) begin
      tail_sum = tail_sum - TailW'(MAX_SEGMENTS);
    end
    tail_cur = PosW'(tail_sum);
    out_free = !out_valid_q || out_ready_i;

    free_slot = '0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (!valid_q[taddr(lv_idx, PosW'(i))]) begin
        free_slot = PosW'(i);
      end
    end

    // trim against the delivery point
    below = in_q.frame_offset < dp_cur;
    diff  = dp_cur - in_q.frame_offset;
    dup   = below && (diff >= OffW'(in_q.frame_length));
    skip  = below ? diff[LenW-1:0] : '0;
    elen  = in_q.frame_length - skip;
    at_dp = below || (in_q.frame_offset == dp_cur);
    sum   = {1'b0, dp_cur} + (OffW + 1)'(elen);
    over  = sum > (OffW + 1)'(BUFFER_BYTES);

    s_off   = seg_rdata[SegW-1:LenW];
    s_len   = seg_rdata[LenW-1:0];
    s_sum   = {1'b0, dp_cur} + (OffW + 1)'(s_len);
    s_over  = s_sum > (OffW + 1)'(BUFFER_BYTES);
    s_match = !err_q && (s_off == dp_cur);
    keep    = !s_match || s_over;
    w_next  = keep ? pos_dec(w_q) : w_q;
  end

  always_comb begin
    st_d        = st_q;
    in_d        = in_q;
    dp_d        = dp_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    p_d         = p_q;
    w_d         = w_q;
    rem_d       = rem_q;
    prog_d      = prog_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    seg_we     = 1'b0;
    seg_waddr  = taddr(lv_idx, free_slot);
    seg_wdata  = {in_q.frame_offset, in_q.frame_length};
    seg_re     = 1'b0;
    seg_raddr  = taddr(lv_idx, ring_rdata);
    ring_we    = 1'b0;
    ring_waddr = taddr(lv_idx, tail_cur);
    ring_wdata = free_slot;
    ring_re    = 1'b0;
    ring_raddr = taddr(lv_idx, p_q);

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_i;
          err_d = 1'b0;
          st_d  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (bad_lv) begin
          err_d = 1'b1;
          st_d  = ST_FINAL;
        end else if (dup) begin
          st_d = ST_DSTART;
        end else if (at_dp) begin
          if (over) begin
            err_d = 1'b1;
            st_d  = ST_FINAL;
          end else if (out_free) begin
            out_valid_d         = 1'b1;
            out_d               = '0;
            out_d.kind          = KIND_COPY;
            out_d.skip_bytes    = skip;
            out_d.dest_offset   = dp_cur;
            out_d.copy_length   = elen;
            out_d.delivered_upto = sum[OffW-1:0];
            out_d.held_segments = HeldW'(cnt_cur);
            dp_d[lv_idx]        = sum[OffW-1:0];
            st_d                = ST_DSTART;
          end
        end else if (32'(cnt_cur) >= MAX_SEGMENTS) begin
          err_d = 1'b1;
          st_d  = ST_FINAL;
        end else if (out_free) begin
          seg_we                              = 1'b1;
          ring_we                             = 1'b1;
          valid_d[taddr(lv_idx, free_slot)]   = 1'b1;
          cnt_d[lv_idx]                       = cnt_cur + CntW'(1);
          out_valid_d                         = 1'b1;
          out_d                               = '0;
          out_d.kind                          = KIND_STORE;
          out_d.slot                          = SlotW'(free_slot);
          out_d.dest_offset                   = in_q.frame_offset;
          out_d.copy_length                   = in_q.frame_length;
          out_d.delivered_upto                = dp_cur;
          out_d.held_segments                 = HeldW'(cnt_cur + CntW'(1));
          st_d                                = ST_DSTART;
        end
      end
      ST_DSTART: begin
        // one pass walks the ring newest first and packs survivors to the top
        if (cnt_cur == '0) begin
          st_d = ST_FINAL;
        end else begin
          p_d    = pos_dec(tail_cur);
          w_d    = pos_dec(tail_cur);
          rem_d  = cnt_cur;
          prog_d = 1'b0;
          st_d   = ST_DRD;
        end
      end
      ST_DRD: begin
        ring_re = 1'b1;
        st_d    = ST_DSLOT;
      end
      ST_DSLOT: begin
        seg_re = 1'b1;
        st_d   = ST_DCHK;
      end
      ST_DCHK: begin
        if (keep || out_free) begin
          if (keep) begin
            ring_we    = 1'b1;
            ring_waddr = taddr(lv_idx, w_q);
            ring_wdata = ring_rdata;
            if (s_match) begin
              err_d = 1'b1;
            end
          end else begin
            valid_d[taddr(lv_idx, ring_rdata)] = 1'b0;
            cnt_d[lv_idx]        = cnt_cur - CntW'(1);
            dp_d[lv_idx]         = s_sum[OffW-1:0];
            prog_d               = 1'b1;
            out_valid_d          = 1'b1;
            out_d                = '0;
            out_d.kind           = KIND_MOVE;
            out_d.slot           = SlotW'(ring_rdata);
            out_d.dest_offset    = dp_cur;
            out_d.copy_length    = s_len;
            out_d.delivered_upto = s_sum[OffW-1:0];
            out_d.held_segments  = HeldW'(cnt_cur - CntW'(1));
          end
          w_d   = w_next;
          p_d   = pos_dec(p_q);
          rem_d = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            head_d[lv_idx] = pos_inc(w_next);
            if (err_d) begin
              st_d = ST_FINAL;
            end else if (prog_d) begin
              st_d = ST_DSTART;
            end else begin
              st_d = ST_FINAL;
            end
          end else begin
            st_d = ST_DRD;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.kind           = KIND_FINAL;
          out_d.status         = err_q;
          out_d.delivered_upto = bad_lv ? '0 : dp_cur;
          out_d.held_segments  = bad_lv ? '0 : HeldW'(cnt_cur);
          out_d.last           = 1'b1;
          st_d                 = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      p_q         <= '0;
      w_q         <= '0;
      rem_q       <= '0;
      prog_q      <= 1'b0;
      err_q       <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        dp_q[l]   <= '0;
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      st_q        <= st_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      p_q         <= p_d;
      w_q         <= w_d;
      rem_q       <= rem_d;
      prog_q      <= prog_d;
      err_q       <= err_d;
      dp_q        <= dp_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
